@@ rtl/wsh_pkg.sv @@
// Shared widths, codes, types and reset values for the windowed sample histogram.
package wsh_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 16;
    localparam int NBINS_W    = 7;
    localparam int IDX_W      = 6;
    localparam int TOTAL_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0]    WINDOW_LENGTH_RST = 16'd1024;
    localparam logic [NBINS_W-1:0]  BIN_COUNT_RST     = 7'd16;

    // Exactly -1 in Q1.15: advances the window but lands in no bin.
    localparam logic [SAMPLE_W-1:0] SAMPLE_NONE       = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_BIN_COUNT     = 1'b1
    } cfg_reg_t;

    // One classified sample on its way from front to back.
    typedef struct packed {
        logic [IDX_W-1:0]   bin;
        logic               counted;
        logic               close;
        logic [NBINS_W-1:0] nbins;
    } bin_op_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_PRIME,
        ST_DRAIN
    } back_state_t;

endpackage

@@ rtl/wsh_sample_if.sv @@
// Sample channel: valid/ready handshake carrying one Q1.15 sample.
interface wsh_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [wsh_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/wsh_result_if.sv @@
// Result channel: valid/ready handshake carrying one histogram bin report.
interface wsh_result_if;
    logic                         valid;
    logic                         ready;
    logic [wsh_pkg::IDX_W-1:0]    bin_index;
    logic [wsh_pkg::TOTAL_W-1:0]  bin_total;
    logic                         last;

    modport source (output valid, output bin_index, output bin_total, output last, input ready);
    modport sink   (input valid, input bin_index, input bin_total, input last, output ready);
endinterface

@@ rtl/windowed_sample_histogram.sv @@
// Top level of the windowed sample histogram: config registers, front, queue, back.
//
// Usage:
//   samples : Q1.15 samples in, valid/ready. One sample per cycle is taken
//             while the two-entry queue has room.
//   results : one item per bin at each window end, bin_index 0 up to
//             bin_count-1 in order, bin_total the count, last on the final bin.
//   cfg     : cfg_we/cfg_index/cfg_wdata write window_length (index 0) and
//             bin_count (index 1); write only while the block is idle.
//             window_length 0 acts as 1, bin_count 0 as 1, above MAX_BINS
//             as MAX_BINS. The sample value -32768 is counted toward the
//             window but lands in no bin.
// Window end: the first result of a window is shown once the closing sample has
//   passed the queue, stage 1 and the prime state; the rest follow one per cycle
//   while the receiver is ready. Throughput: 1 sample per cycle inside a window.
//   At each window end the back end is busy through the prime state and the drain
//   (plus receiver stalls) on the single read port of the counter memory; the
//   queue takes two more samples, then samples.ready drops until the drain ends.
// Reset: counters read as zero (per-bin valid flags, no clearing pass),
//   window count zero, window_length 1024, bin_count 16.
// Receiver stall: the current result holds; the drain pauses.
module windowed_sample_histogram #(
    parameter int MAX_BINS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wsh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wsh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    wsh_sample_if.sink                       samples,
    wsh_result_if.source                     results
);

    localparam logic [wsh_pkg::NBINS_W-1:0] NBINS_MAX = wsh_pkg::NBINS_W'(MAX_BINS);

    logic [wsh_pkg::LEN_W-1:0]   window_length_reg;
    logic [wsh_pkg::NBINS_W-1:0] bin_count_reg;
    logic [wsh_pkg::LEN_W-1:0]   eff_length;
    logic [wsh_pkg::NBINS_W-1:0] eff_bins;

    logic             front_valid, front_ready;
    wsh_pkg::bin_op_t front_op;
    logic             back_valid, back_ready;
    wsh_pkg::bin_op_t back_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= wsh_pkg::WINDOW_LENGTH_RST;
            bin_count_reg     <= wsh_pkg::BIN_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (wsh_pkg::cfg_reg_t'(cfg_index))
                wsh_pkg::REG_WINDOW_LENGTH: window_length_reg <= cfg_wdata;
                wsh_pkg::REG_BIN_COUNT:     bin_count_reg <= cfg_wdata[wsh_pkg::NBINS_W-1:0];
                default: ;
            endcase
        end
    end

    // zero and out-of-range settings folded into usable values
    always_comb
    begin
        eff_length = (window_length_reg == '0) ? wsh_pkg::LEN_W'(1) : window_length_reg;
        if (bin_count_reg == '0)
        begin
            eff_bins = wsh_pkg::NBINS_W'(1);
        end
        else if (bin_count_reg > NBINS_MAX)
        begin
            eff_bins = NBINS_MAX;
        end
        else
        begin
            eff_bins = bin_count_reg;
        end
    end

    wsh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .eff_length (eff_length),
        .eff_bins   (eff_bins),
        .op_valid   (front_valid),
        .op_ready   (front_ready),
        .op         (front_op)
    );

    wsh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_op     (back_op)
    );

    wsh_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .op       (back_op),
        .results  (results)
    );

endmodule

@@ rtl/wsh_queue.sv @@
// Two-entry queue of classified samples between front and back.
module wsh_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  wsh_pkg::bin_op_t push_op,
    output logic             pop_valid,
    input  logic             pop_ready,
    output wsh_pkg::bin_op_t pop_op
);

    wsh_pkg::bin_op_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             push, pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ rtl/wsh_front.sv @@
// Front end: takes samples, finds each one's bin and tracks the window count.
module wsh_front (
    input  logic                          clk,
    input  logic                          rst_n,
    wsh_sample_if.sink                    samples,
    input  logic [wsh_pkg::LEN_W-1:0]     eff_length,
    input  logic [wsh_pkg::NBINS_W-1:0]   eff_bins,
    output logic                          op_valid,
    input  logic                          op_ready,
    output wsh_pkg::bin_op_t              op
);

    localparam int PROD_W = wsh_pkg::SAMPLE_W + wsh_pkg::NBINS_W;

    logic [wsh_pkg::LEN_W-1:0]    count_reg, count_next;
    logic [wsh_pkg::LEN_W-1:0]    count_inc;
    logic [wsh_pkg::SAMPLE_W-1:0] offset;
    logic [PROD_W-1:0]            prod;
    logic                         close;
    logic                         fire;

    assign samples.ready = op_ready;
    assign op_valid      = samples.valid;
    assign fire          = samples.valid && op_ready;

    // s + 32768 is the sample with its sign bit flipped
    assign offset    = samples.sample ^ wsh_pkg::SAMPLE_NONE;
    assign prod      = PROD_W'(offset) * PROD_W'(eff_bins);
    assign count_inc = count_reg + 1'b1;
    assign close     = (count_inc >= eff_length);

    always_comb
    begin
        op.bin     = prod[wsh_pkg::SAMPLE_W +: wsh_pkg::IDX_W];
        op.counted = (samples.sample != wsh_pkg::SAMPLE_NONE);
        op.close   = close;
        op.nbins   = eff_bins;
    end

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            count_next = close ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/wsh_back.sv @@
// Back end: bin counter memory, increment path and window-end drain.
module wsh_back #(
    parameter int MAX_BINS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_ready,
    input  wsh_pkg::bin_op_t op,
    wsh_result_if.source     results
);

    localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    wsh_pkg::back_state_t state_reg, state_next;

    logic [wsh_pkg::TOTAL_W-1:0] count_mem_reg [MAX_BINS];
    logic [wsh_pkg::TOTAL_W-1:0] rd_data_reg;
    logic [MAX_BINS-1:0]         valid_reg;

    wsh_pkg::bin_op_t            s1_reg;
    logic                        s1_valid_reg;
    logic                        last_wr_valid_reg;
    logic [wsh_pkg::IDX_W-1:0]   last_wr_bin_reg;
    logic [wsh_pkg::TOTAL_W-1:0] last_wr_data_reg;

    logic [wsh_pkg::IDX_W-1:0]   k_reg, k_next;
    logic [wsh_pkg::NBINS_W-1:0] nbins_reg, nbins_next;

    logic [BIN_W-1:0]            rd_addr;
    logic                        pop;
    logic                        hit;
    logic [wsh_pkg::TOTAL_W-1:0] cur;
    logic [wsh_pkg::TOTAL_W-1:0] wr_data;
    logic                        wr_en;
    logic                        out_fire;
    logic                        is_last;
    logic                        drain_done;

    // stop taking ops once a window-closing op sits in stage 1
    assign pop      = op_valid && (state_reg == wsh_pkg::ST_RUN)
                      && !(s1_valid_reg && s1_reg.close);
    assign op_ready = pop;

    // read-modify-write: the previous cycle's write is not yet in rd_data_reg
    assign hit     = last_wr_valid_reg && (last_wr_bin_reg == s1_reg.bin);
    assign cur     = hit ? last_wr_data_reg
                   : (valid_reg[s1_reg.bin[BIN_W-1:0]] ? rd_data_reg : '0);
    assign wr_data = cur + 1'b1;
    assign wr_en   = s1_valid_reg && s1_reg.counted;

    assign out_fire   = results.valid && results.ready;
    assign is_last    = ({1'b0, k_reg} == (nbins_reg - 1'b1));
    assign drain_done = out_fire && is_last;

    always_comb
    begin
        case (state_reg)
            wsh_pkg::ST_RUN:   rd_addr = op.bin[BIN_W-1:0];
            wsh_pkg::ST_PRIME: rd_addr = '0;
            wsh_pkg::ST_DRAIN: rd_addr = (out_fire && !is_last) ? BIN_W'(k_reg + 1'b1)
                                                                : k_reg[BIN_W-1:0];
            default:           rd_addr = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsh_pkg::ST_RUN:
            begin
                if (s1_valid_reg && s1_reg.close)
                begin
                    state_next = wsh_pkg::ST_PRIME;
                end
            end
            wsh_pkg::ST_PRIME: state_next = wsh_pkg::ST_DRAIN;
            wsh_pkg::ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = wsh_pkg::ST_RUN;
                end
            end
            default: state_next = wsh_pkg::ST_RUN;
        endcase
    end

    always_comb
    begin
        results.valid     = 1'b0;
        results.bin_index = k_reg;
        results.bin_total = valid_reg[k_reg[BIN_W-1:0]] ? rd_data_reg : '0;
        results.last      = is_last;
        case (state_reg)
            wsh_pkg::ST_DRAIN: results.valid = 1'b1;
            default:           results.valid = 1'b0;
        endcase
    end

    always_comb
    begin
        k_next     = k_reg;
        nbins_next = nbins_reg;
        if (state_reg == wsh_pkg::ST_PRIME)
        begin
            k_next = '0;
        end
        else if (out_fire && !is_last)
        begin
            k_next = k_reg + 1'b1;
        end
        if (s1_valid_reg && s1_reg.close)
        begin
            nbins_next = s1_reg.nbins;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= wsh_pkg::ST_RUN;
            s1_valid_reg      <= 1'b0;
            last_wr_valid_reg <= 1'b0;
            valid_reg         <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            s1_valid_reg      <= pop;
            last_wr_valid_reg <= wr_en;
            if (drain_done)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[s1_reg.bin[BIN_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg <= op;
        end
        last_wr_bin_reg  <= s1_reg.bin;
        last_wr_data_reg <= wr_data;
        k_reg            <= k_next;
        nbins_reg        <= nbins_next;
    end

    // counter memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem_reg[s1_reg.bin[BIN_W-1:0]] <= wr_data;
        end
        rd_data_reg <= count_mem_reg[rd_addr];
    end

endmodule

@@ rtl/wsh_checker.sv @@
// Port-level assertions for the windowed sample histogram, bound to the top level.
module wsh_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          results_valid,
    input logic                          results_ready,
    input logic [wsh_pkg::IDX_W-1:0]     results_bin_index,
    input logic [wsh_pkg::TOTAL_W-1:0]   results_bin_total,
    input logic                          results_last
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=>
            $stable(results_bin_index) && $stable(results_bin_total) && $stable(results_last))
        else $error("result payload changed while stalled");

    a_first_bin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results_valid) |-> (results_bin_index == '0))
        else $error("histogram does not start at bin 0");

    a_drain_steps: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && results_ready && !results_last |=>
            results_valid
            && (results_bin_index == wsh_pkg::IDX_W'($past(results_bin_index) + 1'b1)))
        else $error("drain skipped or stalled between bins");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && results_ready && results_last |=> !results_valid)
        else $error("result shown right after the last bin");

endmodule

bind windowed_sample_histogram wsh_checker u_wsh_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .results_valid     (results.valid),
    .results_ready     (results.ready),
    .results_bin_index (results.bin_index),
    .results_bin_total (results.bin_total),
    .results_last      (results.last)
);

@@ verif/windowed_sample_histogram_test.sv @@
// Self-checking testbench for the windowed sample histogram: scoreboard, stimulus, checks.
module windowed_sample_histogram_test;

    localparam int HIST_BINS = 64;
    // Cycles the receiver holds off during the back-pressure phase.
    localparam int LONG_HOLD = 300;
    // Quiet cycles after the last result before a register write: covers the
    // input queue plus the front-to-result pipeline with margin.
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS = 400;

    // One bin report as it leaves the block.
    typedef struct packed {
        logic [wsh_pkg::IDX_W-1:0]   bin_index;
        logic [wsh_pkg::TOTAL_W-1:0] bin_total;
        logic                        last;
    } bin_report_t;

    // Tracks the histogram the block should be building and the bin
    // reports it owes; checks each report against the oldest one owed.
    class hist_scoreboard;
        logic [wsh_pkg::LEN_W-1:0]   win_len;
        logic [wsh_pkg::NBINS_W-1:0] bin_cfg;
        logic [wsh_pkg::TOTAL_W-1:0] tally [HIST_BINS];
        logic [wsh_pkg::LEN_W-1:0]   taken;
        bin_report_t                 pending_bins [$];
        int                          errors;
        int                          windows;
        int                          checked;
        int                          samples;

        function new();
            win_len = wsh_pkg::WINDOW_LENGTH_RST;
            bin_cfg = wsh_pkg::BIN_COUNT_RST;
            foreach (tally[i])
                tally[i] = '0;
            taken   = '0;
            errors  = 0;
            windows = 0;
            checked = 0;
            samples = 0;
        endfunction

        function void set_reg(wsh_pkg::cfg_reg_t r, logic [wsh_pkg::CFG_DATA_W-1:0] v);
            case (r)
                wsh_pkg::REG_WINDOW_LENGTH: win_len = v[wsh_pkg::LEN_W-1:0];
                wsh_pkg::REG_BIN_COUNT:     bin_cfg = v[wsh_pkg::NBINS_W-1:0];
                default:                    ;
            endcase
        endfunction

        // Zero bins acts as one, anything past the array size saturates.
        function int eff_bins();
            if (bin_cfg == 0)
                return 1;
            if (bin_cfg > HIST_BINS)
                return HIST_BINS;
            return int'(bin_cfg);
        endfunction

        function void note_sample(logic [wsh_pkg::SAMPLE_W-1:0] raw);
            logic [wsh_pkg::NBINS_W-1:0]  nb;
            logic [wsh_pkg::SAMPLE_W-1:0] off;
            logic [22:0]                  prod;
            logic [6:0]                   bin;
            logic [wsh_pkg::LEN_W-1:0]    lim;
            bin_report_t                  rep;
            nb = wsh_pkg::NBINS_W'(eff_bins());
            samples++;
            // exactly -1 lands in no bin but still counts toward the window
            if (raw != wsh_pkg::SAMPLE_NONE)
            begin
                off  = raw ^ 16'h8000;
                prod = off * nb;
                bin  = prod[22:16];
                if (bin < HIST_BINS)
                    tally[bin] = tally[bin] + 1'b1;
            end
            taken = taken + 1'b1;
            lim   = (win_len == 0) ? wsh_pkg::LEN_W'(1) : win_len;
            if (taken < lim)
                return;
            for (int k = 0; k < int'(nb); k++)
            begin
                rep.bin_index = wsh_pkg::IDX_W'(k);
                rep.bin_total = tally[k];
                rep.last      = (k + 1 == int'(nb));
                pending_bins.push_back(rep);
            end
            foreach (tally[i])
                tally[i] = '0;
            taken = '0;
            windows++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] error: %s", $realtime, msg);
        endtask

        task check_bin_report(bin_report_t got);
            bin_report_t want;
            if (pending_bins.size() == 0)
            begin
                report_mismatch($sformatf("unexpected bin report idx=%0d total=%0d last=%0b",
                                          got.bin_index, got.bin_total, got.last));
                return;
            end
            want = pending_bins.pop_front();
            checked++;
            if (got.bin_index != want.bin_index)
                report_mismatch($sformatf("bin_index %0d, want %0d",
                                          got.bin_index, want.bin_index));
            if (got.bin_total != want.bin_total)
                report_mismatch($sformatf("bin %0d total %0d, want %0d",
                                          want.bin_index, got.bin_total, want.bin_total));
            if (got.last != want.last)
                report_mismatch($sformatf("bin %0d last %0b, want %0b",
                                          want.bin_index, got.last, want.last));
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [wsh_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [wsh_pkg::CFG_DATA_W-1:0]   cfg_wdata;

    wsh_sample_if samp_ch ();
    wsh_result_if res_ch ();

    hist_scoreboard sb;

    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int hold_req;
    int random_sent;

    windowed_sample_histogram u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .samples   (samp_ch),
        .results   (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Safety net: far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one sample and hold it until taken. Valid is left high so that
    // back-to-back items need no toggle; callers drop it for a gap.
    task automatic send_sample(input logic [wsh_pkg::SAMPLE_W-1:0] s);
        samp_ch.valid  <= 1'b1;
        samp_ch.sample <= s;
        do
            @(posedge clk);
        while (!samp_ch.ready);
        sb.note_sample(s);
    endtask

    // Register writes are legal only with nothing in flight: wait for every
    // owed report, then let the pipeline settle.
    task automatic wait_drained();
        while (sb.pending_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One phase: drain, program both registers, then stream n samples with
    // random content and bursty idling (or none when gapless).
    task automatic run_phase(input int wl, input int bc_data, input int n,
                             input bit gapless, input bit long_hold);
        logic [wsh_pkg::SAMPLE_W-1:0] smp;
        int                           burst_left;
        int                           nb;
        int                           k;
        int                           v;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= wsh_pkg::REG_WINDOW_LENGTH;
        cfg_wdata <= wsh_pkg::CFG_DATA_W'(wl);
        @(posedge clk);
        sb.set_reg(wsh_pkg::REG_WINDOW_LENGTH, wsh_pkg::CFG_DATA_W'(wl));
        cfg_index <= wsh_pkg::REG_BIN_COUNT;
        cfg_wdata <= wsh_pkg::CFG_DATA_W'(bc_data);
        @(posedge clk);
        sb.set_reg(wsh_pkg::REG_BIN_COUNT, wsh_pkg::CFG_DATA_W'(bc_data));
        cfg_we <= 1'b0;
        @(posedge clk);
        if (long_hold)
            hold_req <= hold_req + 1;
        burst_left = $urandom_range(1, 16);
        for (int i = 0; i < n; i++)
        begin
            nb = sb.eff_bins();
            case ($urandom_range(9))
                0, 1, 2, 3, 4:
                    smp = wsh_pkg::SAMPLE_W'($urandom);
                5:
                    case ($urandom_range(4))
                        0:       smp = wsh_pkg::SAMPLE_NONE;
                        1:       smp = 16'h7FFF;
                        2:       smp = 16'h8001;
                        3:       smp = 16'h0000;
                        default: smp = 16'hFFFF;
                    endcase
                6, 7:
                begin
                    // first value of a random bin, or the one just below it
                    k = $urandom_range(nb - 1);
                    v = (k * 65536 + nb - 1) / nb - 32768 - int'($urandom_range(1));
                    if (v < -32768)
                        v = -32768;
                    smp = v[wsh_pkg::SAMPLE_W-1:0];
                end
                default:
                    smp = wsh_pkg::SAMPLE_W'($urandom_range(511)) - 16'd256;
            endcase
            send_sample(smp);
            random_sent++;
            burst_left--;
            if (!gapless && burst_left <= 0)
            begin
                samp_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
        end
        samp_ch.valid <= 1'b0;
    endtask

    // Receiver: check each taken report, then pick ready for the next cycle.
    // Ready follows stretches of a random duty cycle, including always-on.
    initial
    begin
        int          stall_left;
        int          pct;
        int          stretch;
        int          seen;
        bin_report_t got;
        stall_left = 0;
        pct        = 100;
        stretch    = 0;
        seen       = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got.bin_index = res_ch.bin_index;
                got.bin_total = res_ch.bin_total;
                got.last      = res_ch.last;
                sb.check_bin_report(got);
            end
            if (hold_req != seen)
            begin
                seen       = hold_req;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    case ($urandom_range(4))
                        0, 1:    pct = 100;
                        2:       pct = 75;
                        3:       pct = 50;
                        default: pct = 20;
                    endcase
                    stretch = $urandom_range(20, 120);
                end
                stretch--;
                res_ch.ready <= ($urandom_range(99) < pct);
            end
        end
    end

    // Main stimulus.
    initial
    begin
        logic [wsh_pkg::SAMPLE_W-1:0] directed [18];
        int wl;
        int bc;
        directed = '{
            16'h8000, 16'h7FFF, 16'h8001, 16'h0000, 16'hFFFF, 16'h0001,
            16'h4000, 16'hC000, 16'h3FFF, 16'hBFFF, 16'h5555, 16'hAAAA,
            16'h0FFF, 16'hF000, 16'h7000, 16'h8FFF, 16'h8000, 16'h1000
        };
        sb          = new();
        hold_req    = 0;
        random_sent = 0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= wsh_pkg::REG_WINDOW_LENGTH;
        cfg_wdata      <= '0;
        samp_ch.valid  <= 1'b0;
        samp_ch.sample <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings (1024 samples, 16 bins):
        // field extremes, exactly -1 twice, alternating bit patterns,
        // quarter points. The window stays open.
        foreach (directed[i])
            send_sample(directed[i]);
        samp_ch.valid <= 1'b0;

        // Length lowered below the count taken so far: closes on next sample.
        run_phase(5, 16, 10, 1'b0, 1'b0);
        // Length zero acts as one, single bin: a report per sample.
        run_phase(0, 1, 20, 1'b0, 1'b0);
        // Bin count zero acts as one; gapless sender.
        run_phase(1, 0, 15, 1'b1, 1'b0);
        // Full bin set.
        run_phase(7, 64, 28, 1'b0, 1'b0);
        // Bin count past the maximum saturates.
        run_phase(3, 127, 12, 1'b0, 1'b0);
        // Longest window: nothing closes, so the counts stay in the counters.
        run_phase(65535, 64, 20, 1'b0, 1'b0);
        // Bins cut to 4 and length lowered mid-window: only 4 reported,
        // the rest must still be cleared...
        run_phase(12, 4, 25, 1'b0, 1'b0);
        // ...which the next full-width window shows.
        run_phase(10, 64, 20, 1'b0, 1'b0);
        // Back-pressure: receiver holds off while the sender streams, so the
        // queue fills and sample ready drops.
        run_phase(4, 32, 60, 1'b1, 1'b1);

        // Random phases, mostly short windows so reports are plentiful.
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0:       wl = 1;
                1:       wl = $urandom_range(1, 8);
                8:       wl = 0;
                9:       wl = $urandom_range(41, 120);
                default: wl = $urandom_range(2, 40);
            endcase
            case ($urandom_range(9))
                0:       bc = 0;
                1:       bc = $urandom_range(65, 127);
                2:       bc = 64;
                3:       bc = 1;
                default: bc = $urandom_range(2, 63);
            endcase
            // junk above the 7-bit field must be ignored
            if ($urandom_range(3) == 0)
                bc = bc | (int'($urandom_range(511)) << wsh_pkg::NBINS_W);
            run_phase(wl, bc, $urandom_range(10, 40), ($urandom_range(3) == 0), 1'b0);
        end

        while (sb.pending_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 3) @(posedge clk);
        if (sb.pending_bins.size() != 0)
            sb.report_mismatch($sformatf("%0d bin reports never arrived",
                                         sb.pending_bins.size()));

        $display("covered %0d samples over %0d closed windows, %0d bin reports checked",
                 sb.samples, sb.windows, sb.checked);
        $display("lengths 0..65535 and bin counts 0..127 visited, one long receiver hold-off");
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
